>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL of the autotuner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define TGA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/core/tga_pkg.sv
// ----------------------------------------------------------------------------
// Twiddle gain autotuner package
// Sequencer and phase types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tga_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_DIV,
    ST_AVG,
    ST_SUM,
    ST_DECIDE,
    ST_SCALE_FIN,
    ST_GAIN_ADD,
    ST_OUT
  } tga_state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_INC,
    PH_DEC
  } tga_phase_e;

  localparam logic [2:0] REG_TOL    = 3'd0;
  localparam logic [2:0] REG_GP     = 3'd1;
  localparam logic [2:0] REG_GI     = 3'd2;
  localparam logic [2:0] REG_GD     = 3'd3;
  localparam logic [2:0] REG_TUNE   = 3'd4;
  localparam logic [2:0] REG_WARM   = 3'd5;
  localparam logic [2:0] REG_RUNLEN = 3'd6;

  localparam int DIV_W     = 36;
  localparam int DIV_CNT_W = 6;

  localparam logic [30:0] TOL_RST    = 31'd13107;
  localparam logic [9:0]  WARM_RST   = 10'd100;
  localparam logic [9:0]  RUNLEN_RST = 10'd250;

  localparam logic [10:0]        COUNT_MAX = 11'd2047;
  localparam logic signed [15:0] OFF_LIMIT = 16'sd1536;
  localparam logic signed [31:0] PENALTY   = 32'sd256000;
  localparam logic signed [26:0] SUM_MAX   = 27'sh3FFFFFF;
  localparam logic signed [26:0] SUM_MIN   = 27'sh4000000;
  localparam logic signed [31:0] STEP0_RST = 32'sd13107;
  localparam logic signed [31:0] STEPN_RST = 32'sd32768;
  localparam logic signed [31:0] GAIN_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] GAIN_MIN  = 32'sh80000000;
  localparam logic [10:0]        SCALE_DIV = 11'd10;

endpackage

>>> rtl/core/twiddle_gain_autotuner.sv
// ----------------------------------------------------------------------------
// Twiddle gain autotuner
// Coordinate-descent tuner for PID gains with a bit-serial shared divider.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   tuser: func; tdata: cross_error
// m_axis    out  tdata: run_done, off_track, tuning_done, gain_p, gain_i, gain_d
// apb       in   register writes and reads, pready always high
//
// A sample beat passes through ST_SAMPLE and ST_OUT to the output register.
// A twiddle beat passes through a divider pass, ST_AVG, ST_SUM, ST_DECIDE and ST_OUT,
// with a further divider pass, ST_SCALE_FIN and ST_GAIN_ADD when a step size is rescaled;
// the restoring divider yields one quotient bit per cycle.
// Reset is asynchronous and active low. A full output register stalls the
// sequencer in its final state; no new beat is accepted meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twiddle_gain_autotuner #(
  parameter int NUM_GAINS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [15:0] cross_error
  input  logic         s_axis_tuser_i,   // [0] func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] run_done, [1] off_track, [2] tuning_done, [34:3] gain_p,
  // [66:35] gain_i, [98:67] gain_d, [103:99] zero
  output logic [103:0] m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tga_pkg::*;

  localparam int GW = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
  localparam int CW = $clog2(NUM_GAINS + 1);

  tga_state_e state_q, state_d;
  tga_phase_e phase_q;

  logic [30:0]        tol_q;
  logic signed [31:0] init_gain_q [3];
  logic [1:0]         tune_q;
  logic [9:0]         warm_q;
  logic [9:0]         runlen_q;

  logic [10:0]        step_count_q;
  logic signed [26:0] error_sum_q;
  logic               went_off_q;
  logic signed [31:0] best_q;
  logic signed [31:0] gains_q [NUM_GAINS];
  logic signed [31:0] steps_q [NUM_GAINS];

  logic signed [15:0] in_err_q;
  logic               res_rd_q, res_off_q, res_td_q;
  logic               m_valid_q;
  logic [103:0]       m_data_q;

  logic [DIV_W-1:0]     div_q;
  logic [10:0]          rem_q;
  logic [10:0]          dsr_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_neg_q, div_scale_q, avg_zero_q;
  logic signed [31:0]   avg_q;
  logic signed [34:0]   acc_q;
  logic [CW-1:0]        idx_q;

  logic               s_acc, cfg_we, out_free;
  logic               kv, less, gt;
  logic [GW-1:0]      k;
  logic signed [31:0] step_k, cur_step;
  logic [31:0]        step_mag;
  logic [35:0]        m36, scale_prod;
  logic [26:0]        sum_mag;
  logic [11:0]        div_t;
  logic               div_ge;
  logic [10:0]        rem_n;
  logic signed [31:0] avg_val, mag_s;
  logic [10:0]        cnt_n;
  logic signed [27:0] sum28;
  logic signed [26:0] sum_n;
  logic signed [15:0] err;
  logic               err_off;
  logic               gain_we, step_we;
  logic signed [33:0] gain_delta;
  logic signed [31:0] gain_new, step_new;
  logic [31:0]        gout [3];

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [33:0] d);
    logic signed [34:0] s;
    s = 35'(a) + 35'(d);
    if ((s[34:31] == 4'b0000) || (s[34:31] == 4'b1111)) begin
      return s[31:0];
    end
    return s[34] ? GAIN_MIN : GAIN_MAX;
  endfunction

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_we          = psel && penable && pwrite;
  assign pready          = 1'b1;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    case (paddr[4:2])
      REG_TOL:    prdata = {1'b0, tol_q};
      REG_GP:     prdata = init_gain_q[0];
      REG_GI:     prdata = init_gain_q[1];
      REG_GD:     prdata = init_gain_q[2];
      REG_TUNE:   prdata = {30'd0, tune_q};
      REG_WARM:   prdata = {22'd0, warm_q};
      REG_RUNLEN: prdata = {22'd0, runlen_q};
      default:    prdata = '0;
    endcase
  end

  assign kv       = int'(tune_q) < NUM_GAINS;
  assign k        = GW'(tune_q);
  assign step_k   = steps_q[k];
  assign cur_step = kv ? step_k : '0;
  assign less     = avg_q < best_q;
  assign gt       = acc_q > $signed({4'd0, tol_q});

  assign step_mag   = step_k[31] ? 32'(-step_k) : 32'(step_k);
  assign m36        = 36'(step_mag);
  assign scale_prod = (m36 << 3) + m36 + (less ? (m36 << 1) : 36'd0);
  assign sum_mag    = error_sum_q[26] ? 27'(-error_sum_q) : 27'(error_sum_q);

  assign div_t  = {rem_q, div_q[DIV_W-1]};
  assign div_ge = div_t >= {1'b0, dsr_q};
  assign rem_n  = div_ge ? 11'(div_t - {1'b0, dsr_q}) : div_t[10:0];

  assign mag_s   = $signed(div_q[31:0]);
  assign avg_val = (avg_zero_q ? 32'sd0 : (div_neg_q ? -mag_s : mag_s))
                   + (went_off_q ? PENALTY : 32'sd0);

  assign err     = in_err_q;
  assign cnt_n   = (step_count_q < COUNT_MAX) ? step_count_q + 11'd1 : step_count_q;
  assign sum28   = 28'(error_sum_q) + 28'(err);
  assign sum_n   = (sum28[27] != sum28[26]) ? (sum28[27] ? SUM_MIN : SUM_MAX)
                                            : sum28[26:0];
  assign err_off = (err > OFF_LIMIT) || (err < -OFF_LIMIT);

  always_comb begin
    if (!div_neg_q) begin
      step_new = (|div_q[35:31]) ? GAIN_MAX : $signed(div_q[31:0]);
    end else begin
      step_new = ((|div_q[35:32]) || (div_q[31] && (|div_q[30:0])))
                 ? GAIN_MIN : -$signed(div_q[31:0]);
    end
  end

  assign gain_new = sat_add(gains_q[k], gain_delta);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      gout[j] = '0;
    end
    for (int j = 0; j < NUM_GAINS; j++) begin
      if (j < 3) begin
        gout[j] = gains_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    gain_we    = 1'b0;
    step_we    = 1'b0;
    gain_delta = 34'(cur_step);
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = s_axis_tuser_i ? ST_DIV : ST_SAMPLE;
        end
      end
      ST_SAMPLE: state_d = ST_OUT;
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          state_d = div_scale_q ? ST_SCALE_FIN : ST_AVG;
        end
      end
      ST_AVG: state_d = ST_SUM;
      ST_SUM: begin
        if (idx_q == CW'(NUM_GAINS - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_OUT;
        if (gt && kv) begin
          case (phase_q)
            PH_INC: begin
              if (less) begin
                state_d = ST_DIV;
              end else begin
                gain_we    = 1'b1;
                gain_delta = -(34'(cur_step) <<< 1);
              end
            end
            PH_DEC: begin
              gain_we = !less;
              state_d = ST_DIV;
            end
            default: gain_we = 1'b1;
          endcase
        end
      end
      ST_SCALE_FIN: begin
        step_we = kv;
        state_d = ST_GAIN_ADD;
      end
      ST_GAIN_ADD: begin
        gain_we = kv;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q          <= TOL_RST;
      init_gain_q[0] <= '0;
      init_gain_q[1] <= '0;
      init_gain_q[2] <= '0;
      tune_q         <= '0;
      warm_q         <= WARM_RST;
      runlen_q       <= RUNLEN_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_TOL:    tol_q          <= pwdata[30:0];
        REG_GP:     init_gain_q[0] <= pwdata;
        REG_GI:     init_gain_q[1] <= pwdata;
        REG_GD:     init_gain_q[2] <= pwdata;
        REG_TUNE:   tune_q         <= pwdata[1:0];
        REG_WARM:   warm_q         <= pwdata[9:0];
        REG_RUNLEN: runlen_q       <= pwdata[9:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        gains_q[i] <= '0;
        steps_q[i] <= (i == 0) ? STEP0_RST : STEPN_RST;
      end
    end else begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        if (gain_we && (int'(k) == i)) begin
          gains_q[i] <= gain_new;
        end else if (cfg_we && (i < 3) && (int'(paddr[4:2]) == int'(REG_GP) + i)) begin
          gains_q[i] <= pwdata;
        end
        if (step_we && (int'(k) == i)) begin
          steps_q[i] <= step_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      step_count_q <= '0;
      error_sum_q  <= '0;
      went_off_q   <= 1'b0;
      best_q       <= GAIN_MAX;
      m_valid_q    <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_SAMPLE: begin
          step_count_q <= cnt_n;
          if (cnt_n > {1'b0, warm_q}) begin
            error_sum_q <= sum_n;
            if (err_off) begin
              went_off_q <= 1'b1;
            end
          end
        end
        ST_AVG: begin
          step_count_q <= '0;
          error_sum_q  <= '0;
          went_off_q   <= 1'b0;
        end
        ST_DECIDE: begin
          if (gt) begin
            case (phase_q)
              PH_INC: begin
                if (less) begin
                  best_q <= avg_q;
                end else begin
                  phase_q <= PH_DEC;
                end
              end
              PH_DEC: begin
                if (less) begin
                  best_q <= avg_q;
                end
                phase_q <= PH_INC;
              end
              default: begin
                best_q  <= avg_q;
                phase_q <= PH_INC;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          in_err_q    <= s_axis_tdata_i;
          res_rd_q    <= 1'b0;
          res_off_q   <= 1'b0;
          res_td_q    <= 1'b0;
          div_q       <= DIV_W'(sum_mag);
          dsr_q       <= step_count_q;
          rem_q       <= '0;
          div_cnt_q   <= '0;
          div_neg_q   <= error_sum_q[26];
          div_scale_q <= 1'b0;
          avg_zero_q  <= (step_count_q == '0);
        end
      end
      ST_SAMPLE: begin
        res_rd_q  <= cnt_n > {1'b0, runlen_q};
        res_off_q <= (cnt_n > {1'b0, warm_q}) && err_off;
      end
      ST_DIV: begin
        div_q     <= {div_q[DIV_W-2:0], div_ge};
        rem_q     <= rem_n;
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      ST_AVG: begin
        avg_q <= avg_val;
        acc_q <= '0;
        idx_q <= '0;
      end
      ST_SUM: begin
        acc_q <= acc_q + 35'(steps_q[idx_q[GW-1:0]]);
        idx_q <= idx_q + CW'(1);
      end
      ST_DECIDE: begin
        res_td_q    <= !gt;
        div_q       <= scale_prod;
        dsr_q       <= SCALE_DIV;
        rem_q       <= '0;
        div_cnt_q   <= '0;
        div_neg_q   <= step_k[31];
        div_scale_q <= 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          m_data_q <= {5'd0, gout[2], gout[1], gout[0], res_td_q, res_off_q, res_rd_q};
        end
      end
      default: ;
    endcase
  end

  `TGA_ASSERT(a_busy_not_ready, (state_q != ST_IDLE) |-> !s_axis_tready_o, "ready while busy")
  `TGA_ASSERT(a_out_from_load, $rose(m_valid_q) |-> $past(state_q == ST_OUT), "stray output beat")
  `TGA_ASSERT(a_run_cleared, (state_q == ST_AVG) |=> (step_count_q == '0) && !went_off_q, "run state kept")
  `TGA_ASSERT_NEVER(a_flags_excl, m_valid_q && m_data_q[2] && (m_data_q[0] || m_data_q[1]), "flag mix")

endmodule
